/* design/apci_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apci_pkg
// Types and constants for the point-by-point circular arc interpolator.
// ----------------------------------------------------------------------------
package apci_pkg;

  // coordinate, deviation, radius and step widths
  localparam int unsigned COORD_W  = 24;
  localparam int unsigned DEV_W    = 50;
  localparam int unsigned RADIUS_W = 23;
  localparam int unsigned STEP_W   = 16;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // axis codes
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // step code: {axis, negative}
  typedef logic [1:0] move_code_t;

  // [clockwise][deviation negative][quadrant 1..4 as 0..3]
  localparam move_code_t MOVE_TBL [2][2][4] = '{
    '{ '{2'd1, 2'd3, 2'd0, 2'd2}, '{2'd2, 2'd1, 2'd3, 2'd0} },
    '{ '{2'd3, 2'd0, 2'd2, 2'd1}, '{2'd0, 2'd2, 2'd1, 2'd3} }
  };

  // input item
  typedef struct packed {
    logic                       command;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  end_y;
    logic        [RADIUS_W-1:0] radius;
    logic                       clockwise;
  } in_item_t;

  // result item
  typedef struct packed {
    logic                      moved;
    logic                      axis;
    logic                      negative;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic                      done_res;
  } out_item_t;

endpackage
`default_nettype wire

/* design/arc_point_compare_interpolator_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// arc_point_compare_interpolator_top
// Point-by-point comparison circular interpolator for an X/Y axis pair.
// ----------------------------------------------------------------------------
// A tick item is taken into the input register and finished into the result
// register once that is free, so ticks run at one item per clock while the
// output is not stalled. A load item stays in the input register while the
// squares x*x, y*y, r*r and the coordinate-by-step products are registered in
// the load multiply stage ahead of the deviation sum, then moves on likewise.
// The tick deviation update needs no multiplier: the products x*s and y*s
// are kept alongside the point and moved by s*s on each step. When the step
// size is written, s*s is registered and, unless a load or a step completes
// alongside, both products are formed again from the current point.
// in_ready_o follows out_ready_i combinationally when both registers are full
// and the held item is a tick or a load past its multiply stage.
// ----------------------------------------------------------------------------
module arc_point_compare_interpolator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire apci_pkg::in_item_t            in_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      apci_pkg::out_item_t           out_data_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [apci_pkg::STEP_W-1:0]   cfg_data_i
);
  import apci_pkg::*;

  localparam int unsigned SQ_W  = 2 * COORD_W;
  localparam int unsigned RSQ_W = 2 * RADIUS_W;
  localparam int unsigned PRD_W = COORD_W + STEP_W + 1;

  // configuration: step size and its square
  logic [STEP_W-1:0]   step_q;
  logic [2*STEP_W-1:0] step_sq_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= STEP_W'(1);
      step_sq_q <= (2*STEP_W)'(1);
    end else if (cfg_valid_i) begin
      step_q    <= cfg_data_i;
      step_sq_q <= (2*STEP_W)'(cfg_data_i) * (2*STEP_W)'(cfg_data_i);
    end
  end

  // handshake control
  logic     item_v_q, item_v_d;
  logic     ld_phase_q, ld_phase_d;
  logic     out_v_q, out_v_d;
  in_item_t item_q;
  logic     in_acc, out_free, is_tick;
  logic     fire_tick, fire_ld0, fire_ld1, release_item;

  assign in_acc       = in_valid_i && in_ready_o;
  assign out_free     = !out_v_q || out_ready_i;
  assign is_tick      = (item_q.command == CMD_TICK);
  assign fire_tick    = item_v_q && is_tick && out_free;
  assign fire_ld0     = item_v_q && !is_tick && !ld_phase_q;
  assign fire_ld1     = item_v_q && !is_tick && ld_phase_q && out_free;
  assign release_item = fire_tick || fire_ld1;
  assign in_ready_o   = !item_v_q || release_item;

  always_comb begin
    item_v_d = item_v_q;
    if (in_acc) begin
      item_v_d = 1'b1;
    end else if (release_item) begin
      item_v_d = 1'b0;
    end
    ld_phase_d = ld_phase_q;
    if (fire_ld0) begin
      ld_phase_d = 1'b1;
    end else if (fire_ld1) begin
      ld_phase_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (release_item) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q   <= 1'b0;
      ld_phase_q <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      item_v_q   <= item_v_d;
      ld_phase_q <= ld_phase_d;
      out_v_q    <= out_v_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
  end

  // load multiply stage
  logic signed [SQ_W-1:0]  sq_x, sq_y;
  logic        [RSQ_W-1:0] sq_r;
  logic signed [PRD_W-1:0] prd_x, prd_y;
  logic signed [STEP_W:0]  step_s;
  logic [DEV_W-1:0]        sq_x_q, sq_y_q, sq_r_q, prd_x_q, prd_y_q;

  assign step_s = $signed({1'b0, step_q});
  assign sq_x   = SQ_W'(item_q.start_x) * SQ_W'(item_q.start_x);
  assign sq_y   = SQ_W'(item_q.start_y) * SQ_W'(item_q.start_y);
  assign sq_r   = RSQ_W'(item_q.radius) * RSQ_W'(item_q.radius);
  assign prd_x  = PRD_W'(item_q.start_x) * PRD_W'(step_s);
  assign prd_y  = PRD_W'(item_q.start_y) * PRD_W'(step_s);

  always_ff @(posedge clk_i) begin
    if (fire_ld0) begin
      sq_x_q  <= DEV_W'(sq_x);
      sq_y_q  <= DEV_W'(sq_y);
      sq_r_q  <= DEV_W'(sq_r);
      prd_x_q <= DEV_W'(prd_x);
      prd_y_q <= DEV_W'(prd_y);
    end
  end

  // arc state: point, target, deviation, direction and the products c*s
  logic signed [COORD_W-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
  logic signed [COORD_W-1:0] cur_x_d, cur_y_d;
  logic [DEV_W-1:0]          dev_q, dev_d, px_q, px_d, py_q, py_d;
  logic                      dir_cw_q;

  // products of the current point with a newly written step size
  logic signed [STEP_W:0]  cfg_s;
  logic signed [PRD_W-1:0] cfg_prd_x, cfg_prd_y;

  assign cfg_s     = $signed({1'b0, cfg_data_i});
  assign cfg_prd_x = PRD_W'(cur_x_q) * PRD_W'(cfg_s);
  assign cfg_prd_y = PRD_W'(cur_y_q) * PRD_W'(cfg_s);

  // tick step selection
  logic [1:0]         quad;
  logic               at_target;
  logic               dev_neg;
  move_code_t         code;
  logic               step_axis, step_neg;
  logic [COORD_W-1:0] step_c, coord_old, coord_new;
  logic [DEV_W-1:0]   prod_old, prod_new, twice, s_sq, wrap_adj;
  logic               wrapped;

  assign at_target = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
  assign dev_neg   = dev_q[DEV_W-1];
  assign quad      = cur_x_q[COORD_W-1] ? (cur_y_q[COORD_W-1] ? 2'd2 : 2'd1)
                                        : (cur_y_q[COORD_W-1] ? 2'd3 : 2'd0);
  assign code      = MOVE_TBL[dir_cw_q][dev_neg][quad];
  assign step_axis = code[1];
  assign step_neg  = code[0];

  // stepped coordinate and its product with the step size
  assign step_c    = COORD_W'(step_q);
  assign coord_old = (step_axis == AXIS_Y) ? cur_y_q : cur_x_q;
  assign prod_old  = (step_axis == AXIS_Y) ? py_q : px_q;
  assign coord_new = step_neg ? (coord_old - step_c) : (coord_old + step_c);
  assign wrapped   = step_neg ? (coord_old[COORD_W-1] && !coord_new[COORD_W-1])
                              : (!coord_old[COORD_W-1] && coord_new[COORD_W-1]);
  assign s_sq      = DEV_W'(step_sq_q);
  assign wrap_adj  = wrapped ? (DEV_W'(step_q) << COORD_W) : '0;
  assign twice     = prod_old << 1;
  assign prod_new  = step_neg ? (prod_old - s_sq + wrap_adj)
                              : (prod_old + s_sq - wrap_adj);

  // next state
  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    dev_d   = dev_q;
    px_d    = px_q;
    py_d    = py_q;
    if (fire_ld1) begin
      cur_x_d = item_q.start_x;
      cur_y_d = item_q.start_y;
      dev_d   = sq_x_q + sq_y_q - sq_r_q;
      px_d    = prd_x_q;
      py_d    = prd_y_q;
    end else if (fire_tick && !at_target) begin
      dev_d = step_neg ? (dev_q - twice + s_sq) : (dev_q + twice + s_sq);
      if (step_axis == AXIS_Y) begin
        cur_y_d = coord_new;
        py_d    = prod_new;
      end else begin
        cur_x_d = coord_new;
        px_d    = prod_new;
      end
    end else if (cfg_valid_i) begin
      px_d = DEV_W'(cfg_prd_x);
      py_d = DEV_W'(cfg_prd_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      dev_q    <= '0;
      px_q     <= '0;
      py_q     <= '0;
      dir_cw_q <= 1'b0;
    end else begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      dev_q   <= dev_d;
      px_q    <= px_d;
      py_q    <= py_d;
      if (fire_ld1) begin
        tgt_x_q  <= item_q.end_x;
        tgt_y_q  <= item_q.end_y;
        dir_cw_q <= item_q.clockwise;
      end
    end
  end

  // result register
  out_item_t res_d, res_q;

  always_comb begin
    res_d          = '0;
    res_d.pos_x    = cur_x_d;
    res_d.pos_y    = cur_y_d;
    if (fire_ld1) begin
      res_d.done_res = (item_q.start_x == item_q.end_x) &&
                       (item_q.start_y == item_q.end_y);
    end else if (at_target) begin
      res_d.done_res = 1'b1;
    end else begin
      res_d.moved    = 1'b1;
      res_d.axis     = step_axis;
      res_d.negative = step_neg;
      res_d.done_res = (cur_x_d == tgt_x_q) && (cur_y_d == tgt_y_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (release_item) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = res_q;

endmodule
`default_nettype wire

/* design/apci_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apci_checker
// Port-level checks for the circular arc interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module apci_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire apci_pkg::out_item_t         out_data_o,
  input wire logic                        cfg_valid_i,
  input wire logic                        cfg_ready_o
);
  import apci_pkg::*;

  // items accepted but not yet delivered
  logic [2:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed or dropped");

  // no result without an item in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("result item without an accepted input item");

  // at most the input and result registers are occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd2)
    else $error("more items in flight than the block can hold");

  // an idle result carries no step direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.moved |-> !out_data_o.axis && !out_data_o.negative)
    else $error("step fields set on a result without a move");

  // configuration writes never stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind arc_point_compare_interpolator_top apci_checker u_apci_checker (.*);
`default_nettype wire
